// ----- rtl/epve_pkg.sv -----
package epve_pkg;

  // Field widths
  localparam int POS_W    = 32;
  localparam int PERIOD_W = 16;
  localparam int REQ_W    = 16;
  localparam int CONST_W  = 22;
  localparam int SPEED_W  = 23;
  localparam int SUM_W    = 28;
  localparam int CNT_W    = 5;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 48;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_CONSTANT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_REQUEST       = 2'd2;

  localparam logic [CONST_W-1:0] VELOCITY_CONSTANT_RST = 22'd2012500;
  localparam logic [CONST_W-1:0] SPEED_FLOOR_RST       = 22'd128;
  localparam logic [REQ_W-1:0]   MIN_REQUEST_RST       = 16'd500;

  // Boxcar window length
  localparam int AVG_LEN = 20;

  // Restoring divider for constant / period; its dividend register also
  // carries the window sum magnitude into the mean stage
  localparam int DIV_W     = 27;
  localparam int DIV_REM_W = 16;
  localparam int STEP_W    = 5;
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_W - 1);

  // Window mean by reciprocal multiply: x * ceil(2^32 / AVG_LEN) >> 32 is
  // exact for every window sum magnitude below 2^27
  localparam int MEAN_SHIFT   = 32;
  localparam int MEAN_RECIP_W = 32;
  localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP =
    MEAN_RECIP_W'(((64'd1 << MEAN_SHIFT) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN));
  localparam int PROD_W = DIV_W + MEAN_RECIP_W;

  typedef struct packed {
    logic load_in;   // take input transfer, start speed division
    logic div_step;  // one divider iteration
    logic speed;     // finish speed, update window, latch sum magnitude
    logic mean;      // form window mean from sum magnitude
    logic load_out;  // fill output register
  } epve_cmd_t;

  typedef struct packed {
    logic div_done;  // divider on its last iteration
    logic win_full;  // this item closes the averaging window
    logic out_free;  // output register can take a new result
  } epve_stat_t;

endpackage

// ----- rtl/epve_dp.sv -----
module epve_dp import epve_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  epve_cmd_t             cmd,
  output epve_stat_t            stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_W-1:0]       in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_W-1:0]      out_data
);

  logic [CONST_W-1:0]   vel_const;
  logic [CONST_W-1:0]   speed_floor;
  logic signed [REQ_W-1:0] min_request;

  logic [POS_W-1:0]     prev_pos;
  logic                 dir_neg;
  logic signed [SUM_W-1:0] speed_sum;
  logic [CNT_W-1:0]     win_cnt;
  logic signed [SPEED_W-1:0] filt_hold;

  logic                 period_zero;
  logic signed [REQ_W-1:0] req;
  logic [DIV_W-1:0]     dvd;
  logic [DIV_REM_W-1:0] rem;
  logic [DIV_REM_W-1:0] dvs;
  logic [STEP_W-1:0]    step_cnt;
  logic                 win_hit;
  logic                 sum_neg;
  logic signed [SPEED_W-1:0] raw;
  logic                 clr;

  logic [POS_W-1:0]     in_pos;
  logic [PERIOD_W-1:0]  in_period;
  logic signed [REQ_W-1:0] in_req;

  logic [DIV_REM_W:0]   rem_sh;
  logic [DIV_REM_W:0]   rem_diff;
  logic                 fits;

  logic [CONST_W-1:0]   mag;
  logic                 below;
  logic signed [SPEED_W-1:0] raw_next;
  logic                 clr_next;
  logic signed [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0]     sum_abs;
  logic [PROD_W-1:0]    mean_prod;
  logic signed [SPEED_W-1:0] filt_new;
  logic signed [SPEED_W-1:0] filt_out;

  assign in_pos    = in_data[POS_W-1:0];
  assign in_period = in_data[POS_W+PERIOD_W-1:POS_W];
  assign in_req    = in_data[IN_W-1:POS_W+PERIOD_W];

  // Divider iteration: shift in one dividend bit, trial subtract
  always_comb begin
    rem_sh   = {rem, dvd[DIV_W-1]};
    rem_diff = rem_sh - {1'b0, dvs};
    fits     = rem_sh >= {1'b0, dvs};
  end

  // Speed from quotient, minimum check and window sum
  always_comb begin
    mag      = dvd[CONST_W-1:0];
    below    = mag < speed_floor;
    raw_next = '0;
    clr_next = 1'b0;
    if (!period_zero) begin
      if (below) begin
        clr_next = req < min_request;
      end else begin
        raw_next = dir_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
    end
    sum_next = speed_sum + SUM_W'(raw_next);
    sum_abs  = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
  end

  // Window mean magnitude by reciprocal multiply
  assign mean_prod = PROD_W'(dvd) * PROD_W'(MEAN_RECIP);

  // Signed mean from quotient; truncation toward zero
  always_comb begin
    filt_new = sum_neg ? -$signed(dvd[SPEED_W-1:0]) : $signed(dvd[SPEED_W-1:0]);
    filt_out = win_hit ? filt_new : filt_hold;
  end

  assign stat.div_done = step_cnt == DIV_LAST;
  assign stat.win_full = win_cnt == CNT_W'(AVG_LEN - 1);
  assign stat.out_free = !out_valid || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vel_const   <= VELOCITY_CONSTANT_RST;
      speed_floor <= SPEED_FLOOR_RST;
      min_request <= MIN_REQUEST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VELOCITY_CONSTANT: vel_const   <= cfg_data;
        REG_SPEED_FLOOR:       speed_floor <= cfg_data;
        REG_MIN_REQUEST:       min_request <= cfg_data[REQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Estimator state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos  <= '0;
      dir_neg   <= 1'b0;
      speed_sum <= '0;
      win_cnt   <= '0;
      filt_hold <= '0;
    end else begin
      if (cmd.load_in) begin
        prev_pos <= in_pos;
        if (in_pos > prev_pos) begin
          dir_neg <= 1'b0;
        end else if (in_pos < prev_pos) begin
          dir_neg <= 1'b1;
        end
      end
      if (cmd.speed) begin
        if (stat.win_full) begin
          speed_sum <= '0;
          win_cnt   <= '0;
        end else begin
          speed_sum <= sum_next;
          win_cnt   <= win_cnt + 1'b1;
        end
      end
      if (cmd.load_out && win_hit) begin
        filt_hold <= filt_new;
      end
    end
  end

  // Divider and per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      period_zero <= in_period == '0;
      req         <= in_req;
      dvd         <= DIV_W'(vel_const);
      rem         <= '0;
      dvs         <= in_period;
      step_cnt    <= '0;
    end else if (cmd.div_step) begin
      dvd      <= {dvd[DIV_W-2:0], fits};
      rem      <= fits ? rem_diff[DIV_REM_W-1:0] : rem_sh[DIV_REM_W-1:0];
      step_cnt <= step_cnt + 1'b1;
    end else if (cmd.speed) begin
      raw     <= raw_next;
      clr     <= clr_next;
      win_hit <= stat.win_full;
      sum_neg <= sum_next[SUM_W-1];
      dvd     <= sum_abs[DIV_W-1:0];
    end else if (cmd.mean) begin
      dvd <= mean_prod[PROD_W-1:MEAN_SHIFT];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {clr, filt_out, win_hit, raw};
    end
  end

endmodule

// ----- rtl/epve_ctrl.sv -----
module epve_ctrl import epve_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  epve_stat_t stat,
  output epve_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIVS  = 5'b00010,
    S_SPEED = 5'b00100,
    S_MEAN  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;

  // Sequence one item: speed division, window update, window mean when the window closes, output
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DIVS;
        end
      end
      S_DIVS: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_SPEED;
      end
      S_SPEED: begin
        cmd.speed  = 1'b1;
        state_next = stat.win_full ? S_MEAN : S_OUT;
      end
      S_MEAN: begin
        cmd.mean   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("output register overwritten while full");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DIVS)
    else $error("accepted transfer did not start the divider");

  a_div_done_speed: assert property (@(posedge clk) disable iff (rst)
    state == S_DIVS && stat.div_done |=> state == S_SPEED && $past(cmd.div_step))
    else $error("speed division did not finish into speed update");

  a_window_mean: assert property (@(posedge clk) disable iff (rst)
    cmd.speed && stat.win_full |=> state == S_MEAN)
    else $error("closed window skipped mean stage");

endmodule

// ----- rtl/encoder_period_velocity_estimator_unit.sv -----
// Channel   Direction  Payload (low bit first)
// s_axis    in         position[31:0], pulse_period[47:32], requested_velocity[63:48]
// m_axis    out        raw_speed[22:0], filtered_valid[23], filtered_speed[46:24],
//                      clear_integral[47]
// cfg       in         cfg_index 0..2, cfg_data up to 22 bits, write on cfg_we
//
// Each item runs a 27-step restoring divider to form constant / period; the
// window sum / 20 comes from a reciprocal multiply in an extra mean state
// when the item closes an averaging window. Rst is synchronous and restores
// register defaults and clears previous position, direction, sum, window
// count, held mean and output valid. A new transfer is taken while the
// previous result still waits on m_axis; a stalled m_axis holds the next
// result inside until the output register frees.
module encoder_period_velocity_estimator_unit import epve_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // position, pulse_period, requested_velocity
  input  logic [IN_W-1:0]       s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // raw_speed, filtered_valid, filtered_speed, clear_integral
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  epve_cmd_t  cmd;
  epve_stat_t stat;

  epve_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  epve_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
